/* rtl/edrs_pkg.sv */
// shared types and constants for the elevator disk request selector
package edrs_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_W   = 4;
  localparam int TRACK_W  = 7;
  localparam int SECTOR_W = 3;
  localparam int POS_W    = TRACK_W + SECTOR_W;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_SEL = 1'b1;

  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             qual;
    logic             better;
    logic [POS_W-1:0] span;
  } cmp_t;

endpackage

/* rtl/edrs_dist_cmp.sv */
// shared distance and compare unit used once per scanned slot
module edrs_dist_cmp (
  input  logic [edrs_pkg::POS_W-1:0] head_pos,
  input  logic [edrs_pkg::POS_W-1:0] req_pos,
  input  logic                       dir,
  input  logic                       pending,
  input  logic                       best_found,
  input  logic [edrs_pkg::POS_W-1:0] best_dist,
  output edrs_pkg::cmp_t             res
);

  logic [edrs_pkg::POS_W:0] diff;

  always_comb begin
    if (dir == edrs_pkg::DIR_DOWN) begin
      diff = {1'b0, head_pos} - {1'b0, req_pos};
    end else begin
      diff = {1'b0, req_pos} - {1'b0, head_pos};
    end
    res.span   = diff[edrs_pkg::POS_W-1:0];
    res.qual   = pending && !diff[edrs_pkg::POS_W];
    res.better = res.qual && (!best_found || (res.span < best_dist));
  end

endmodule

/* rtl/elevator_disk_request_selector_top.sv */
// top level of the elevator disk request selector
// An enqueue request is written into its slot in the accept cycle and marks it pending.
// A select request scans the 16 slots one per cycle through a single distance/compare
// unit, keeping the nearest pending entry ahead of the head (lowest slot on a tie).
// If none lies ahead, the direction flips and a second scan runs. The input stalls
// from accept until the result is handed to the output register. An empty table
// gives found = 0 with zeroed fields and the flipped direction. The result sits in
// an output register, so the next request is taken while it waits.
module elevator_disk_request_selector_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [edrs_pkg::SLOT_W-1:0]   slot,
  input  logic [edrs_pkg::TRACK_W-1:0]  req_track_in,
  input  logic [edrs_pkg::SECTOR_W-1:0] req_sector_in,
  input  logic                          req_write_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [edrs_pkg::SLOT_W-1:0]   chosen_slot,
  output logic [edrs_pkg::TRACK_W-1:0]  chosen_track,
  output logic [edrs_pkg::SECTOR_W-1:0] chosen_sector,
  output logic                          chosen_write,
  output logic                          sweep_dir
);

  edrs_pkg::state_t state, state_next;

  logic [edrs_pkg::TRACK_W-1:0]  tbl_track  [edrs_pkg::SLOTS];
  logic [edrs_pkg::SECTOR_W-1:0] tbl_sector [edrs_pkg::SLOTS];
  logic                          tbl_write  [edrs_pkg::SLOTS];
  logic [edrs_pkg::SLOTS-1:0]    pending;

  logic [edrs_pkg::TRACK_W-1:0]  head_track;
  logic [edrs_pkg::SECTOR_W-1:0] head_sector;
  logic                          direction;

  logic [edrs_pkg::SLOT_W-1:0]   idx;
  logic                          pass;
  logic                          best_found;
  logic [edrs_pkg::POS_W-1:0]    best_dist;
  logic [edrs_pkg::SLOT_W-1:0]   best_slot;
  logic [edrs_pkg::TRACK_W-1:0]  best_track;
  logic [edrs_pkg::SECTOR_W-1:0] best_sector;
  logic                          best_write;

  logic                          accept;
  logic                          start_sel;
  logic                          do_enq;
  logic                          scan_step;
  logic                          last_idx;
  logic                          restart;
  logic                          emit_go;

  edrs_pkg::cmp_t                cmp;

  assign accept    = in_valid && !in_stall;
  assign do_enq    = accept && (command == edrs_pkg::CMD_ENQ);
  assign start_sel = accept && (command == edrs_pkg::CMD_SEL);
  assign last_idx  = (idx == edrs_pkg::SLOT_W'(edrs_pkg::SLOTS - 1));

  edrs_dist_cmp u_cmp (
    .head_pos   ({head_track, head_sector}),
    .req_pos    ({tbl_track[idx], tbl_sector[idx]}),
    .dir        (direction),
    .pending    (pending[idx]),
    .best_found (best_found),
    .best_dist  (best_dist),
    .res        (cmp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      edrs_pkg::ST_IDLE: begin
        if (start_sel) state_next = edrs_pkg::ST_SCAN;
      end
      edrs_pkg::ST_SCAN: begin
        if (last_idx) state_next = edrs_pkg::ST_CHECK;
      end
      edrs_pkg::ST_CHECK: begin
        if (best_found || pass) begin
          state_next = edrs_pkg::ST_EMIT;
        end else begin
          state_next = edrs_pkg::ST_SCAN;
        end
      end
      edrs_pkg::ST_EMIT: begin
        if (emit_go) state_next = edrs_pkg::ST_IDLE;
      end
      default: state_next = edrs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    scan_step = 1'b0;
    restart   = 1'b0;
    emit_go   = 1'b0;
    unique case (state)
      edrs_pkg::ST_IDLE:  in_stall  = 1'b0;
      edrs_pkg::ST_SCAN:  scan_step = 1'b1;
      edrs_pkg::ST_CHECK: restart   = !best_found && !pass;
      edrs_pkg::ST_EMIT:  emit_go   = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request table
  always_ff @(posedge clk) begin
    if (do_enq) begin
      tbl_track[slot]  <= req_track_in;
      tbl_sector[slot] <= req_sector_in;
      tbl_write[slot]  <= req_write_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= '0;
      head_track  <= '0;
      head_sector <= '0;
      direction   <= edrs_pkg::DIR_UP;
    end else begin
      if (do_enq) pending[slot] <= 1'b1;
      if (restart) direction <= ~direction;
      if (emit_go && best_found) begin
        pending[best_slot] <= 1'b0;
        head_track         <= best_track;
        head_sector        <= best_sector;
      end
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      pass       <= 1'b0;
      best_found <= 1'b0;
    end else begin
      if (start_sel) begin
        idx        <= '0;
        pass       <= 1'b0;
        best_found <= 1'b0;
      end else if (restart) begin
        idx        <= '0;
        pass       <= 1'b1;
        best_found <= 1'b0;
      end else if (scan_step) begin
        idx <= idx + 1'b1;
        if (cmp.better) best_found <= 1'b1;
      end
    end
  end

  // best candidate so far
  always_ff @(posedge clk) begin
    if (scan_step && cmp.better) begin
      best_dist   <= cmp.span;
      best_slot   <= idx;
      best_track  <= tbl_track[idx];
      best_sector <= tbl_sector[idx];
      best_write  <= tbl_write[idx];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      found     <= best_found;
      sweep_dir <= direction;
      if (best_found) begin
        chosen_slot   <= best_slot;
        chosen_track  <= best_track;
        chosen_sector <= best_sector;
        chosen_write  <= best_write;
      end else begin
        chosen_slot   <= '0;
        chosen_track  <= '0;
        chosen_sector <= '0;
        chosen_write  <= 1'b0;
      end
    end
  end

endmodule

/* sim/request_pick_checker.sv */
`timescale 1ns / 1ps
// scoreboard for the elevator disk request selector: predicts each pick and compares results
module request_pick_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          command,
  input  logic [edrs_pkg::SLOT_W-1:0]   slot,
  input  logic [edrs_pkg::TRACK_W-1:0]  req_track_in,
  input  logic [edrs_pkg::SECTOR_W-1:0] req_sector_in,
  input  logic                          req_write_in,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          found,
  input  logic [edrs_pkg::SLOT_W-1:0]   chosen_slot,
  input  logic [edrs_pkg::TRACK_W-1:0]  chosen_track,
  input  logic [edrs_pkg::SECTOR_W-1:0] chosen_sector,
  input  logic                          chosen_write,
  input  logic                          sweep_dir,
  output int                            fail_count,
  output int                            awaited
);
  import edrs_pkg::*;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [TRACK_W-1:0]  track;
    logic [SECTOR_W-1:0] sector;
    logic                wr;
    logic                dir;
  } pick_t;

  logic [SLOTS-1:0]    busy_slots;
  logic [TRACK_W-1:0]  slot_track [SLOTS];
  logic [SECTOR_W-1:0] slot_sector [SLOTS];
  logic                slot_write [SLOTS];
  logic [TRACK_W-1:0]  head_track;
  logic [SECTOR_W-1:0] head_sector;
  logic                sweep;
  pick_t               picks_due [$];
  int                  mismatches = 0;
  int                  backlog = 0;

  assign fail_count = mismatches;
  assign awaited    = backlog;

  task automatic report_mismatch(string what, int got_v, int want_v);
    $display("checker: %s mismatch, got %0d expected %0d at %0t", what, got_v, want_v, $time);
    mismatches++;
  endtask

  // nearest pending request ahead of the head, lowest slot on a tie, -1 if none
  function automatic int nearest_slot(logic down);
    int best, best_dist, span, req_pos, head_pos, i;
    best      = -1;
    best_dist = 0;
    head_pos  = {head_track, head_sector};
    for (i = 0; i < SLOTS; i++) begin
      if (busy_slots[i]) begin
        req_pos = {slot_track[i], slot_sector[i]};
        span = (down == DIR_DOWN) ? head_pos - req_pos : req_pos - head_pos;
        if (span >= 0 && (best < 0 || span < best_dist)) begin
          best      = i;
          best_dist = span;
        end
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin : watch
    pick_t want;
    pick_t got;
    int    pick;
    if (rst) begin
      busy_slots  = '0;
      head_track  = '0;
      head_sector = '0;
      sweep       = DIR_UP;
      picks_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {found, chosen_slot, chosen_track, chosen_sector, chosen_write, sweep_dir};
        if (picks_due.size() == 0) begin
          report_mismatch("result with no select waiting, slot", got.slot, -1);
        end else begin
          want = picks_due.pop_front();
          if (got.found !== want.found) report_mismatch("found", got.found, want.found);
          if (got.slot !== want.slot) report_mismatch("chosen_slot", got.slot, want.slot);
          if (got.track !== want.track) report_mismatch("chosen_track", got.track, want.track);
          if (got.sector !== want.sector)
            report_mismatch("chosen_sector", got.sector, want.sector);
          if (got.wr !== want.wr) report_mismatch("chosen_write", got.wr, want.wr);
          if (got.dir !== want.dir) report_mismatch("sweep_dir", got.dir, want.dir);
        end
      end
      if (in_valid && !in_stall) begin
        if (command == CMD_ENQ) begin
          slot_track[slot]  = req_track_in;
          slot_sector[slot] = req_sector_in;
          slot_write[slot]  = req_write_in;
          busy_slots[slot]  = 1'b1;
        end else begin
          pick = nearest_slot(sweep);
          // nothing ahead: reverse the sweep and look the other way
          if (pick < 0) begin
            sweep = ~sweep;
            pick  = nearest_slot(sweep);
          end
          want = '0;
          if (pick >= 0) begin
            head_track       = slot_track[pick];
            head_sector      = slot_sector[pick];
            busy_slots[pick] = 1'b0;
            want.found       = 1'b1;
            want.slot        = SLOT_W'(pick);
            want.track       = head_track;
            want.sector      = head_sector;
            want.wr          = slot_write[pick];
          end
          want.dir = sweep;
          picks_due.push_back(want);
        end
      end
    end
    backlog = picks_due.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// top of the elevator disk request selector testbench: clock, reset, request stimulus, verdict
module testbench;
  import edrs_pkg::*;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int RANDOM_REQUESTS = 850;
  localparam int HOLD_CYCLES     = 300;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                in_valid      = 1'b0;
  logic                command       = CMD_ENQ;
  logic [SLOT_W-1:0]   slot          = '0;
  logic [TRACK_W-1:0]  req_track_in  = '0;
  logic [SECTOR_W-1:0] req_sector_in = '0;
  logic                req_write_in  = 1'b0;
  logic                out_stall     = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic                found;
  logic [SLOT_W-1:0]   chosen_slot;
  logic [TRACK_W-1:0]  chosen_track;
  logic [SECTOR_W-1:0] chosen_sector;
  logic                chosen_write;
  logic                sweep_dir;
  int                  fail_count;
  int                  awaited;
  int                  sent_items  = 0;
  int                  cycle_count = 0;
  int                  stop_count  = 0;
  bit                  gaps_on     = 1'b0;
  bit                  held_once   = 1'b0;

  elevator_disk_request_selector_top DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .slot          (slot),
    .req_track_in  (req_track_in),
    .req_sector_in (req_sector_in),
    .req_write_in  (req_write_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .chosen_slot   (chosen_slot),
    .chosen_track  (chosen_track),
    .chosen_sector (chosen_sector),
    .chosen_write  (chosen_write),
    .sweep_dir     (sweep_dir)
  );

  request_pick_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .slot          (slot),
    .req_track_in  (req_track_in),
    .req_sector_in (req_sector_in),
    .req_write_in  (req_write_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .chosen_slot   (chosen_slot),
    .chosen_track  (chosen_track),
    .chosen_sector (chosen_sector),
    .chosen_write  (chosen_write),
    .sweep_dir     (sweep_dir),
    .fail_count    (fail_count),
    .awaited       (awaited)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_request(logic cmd, logic [SLOT_W-1:0] s, logic [TRACK_W-1:0] t,
                              logic [SECTOR_W-1:0] sec, logic w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    slot          <= s;
    req_track_in  <= t;
    req_sector_in <= sec;
    req_write_in  <= w;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  task automatic enqueue(logic [SLOT_W-1:0] s, logic [TRACK_W-1:0] t,
                         logic [SECTOR_W-1:0] sec, logic w);
    send_request(CMD_ENQ, s, t, sec, w);
  endtask

  // slot and request fields are don't-care for a select, so fill them with noise
  task automatic select_next();
    send_request(CMD_SEL, SLOT_W'($urandom()), TRACK_W'($urandom()),
                 SECTOR_W'($urandom()), 1'($urandom()));
  endtask

  // receiver: random stall bursts, plus one long hold-off to back the block up
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held_once && sent_items >= 150) begin
        held_once = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int                  burst;
    logic [SLOT_W-1:0]   s;
    logic [TRACK_W-1:0]  t;
    logic [SECTOR_W-1:0] sec;
    logic [TRACK_W-1:0]  last_t;
    logic [SECTOR_W-1:0] last_sec;
    last_t   = '0;
    last_sec = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table flips the sweep each time
    select_next();
    select_next();
    // field extremes, a tie at the head, an overwrite of a pending slot
    enqueue(4'd0, 7'd127, 3'd7, 1'b1);
    enqueue(4'd15, 7'd0, 3'd0, 1'b0);
    enqueue(4'd5, 7'd0, 3'd0, 1'b1);
    enqueue(4'd3, 7'd64, 3'd3, 1'b0);
    enqueue(4'd3, 7'd10, 3'd5, 1'b1);
    repeat (5) select_next();
    // sweeping down from the top: one request at the head, a tie further down
    enqueue(4'd9, 7'd127, 3'd7, 1'b0);
    enqueue(4'd1, 7'd60, 3'd0, 1'b1);
    enqueue(4'd2, 7'd60, 3'd0, 1'b0);
    enqueue(4'd12, 7'd100, 3'd4, 1'b1);
    repeat (4) select_next();
    // only a request behind the head: reverse and go up
    enqueue(4'd6, 7'd127, 3'd0, 1'b1);
    select_next();
    select_next();

    stop_count = sent_items + RANDOM_REQUESTS;
    while (sent_items < stop_count) begin
      gaps_on = (sent_items < 250) ||
                (sent_items >= 400 && sent_items < stop_count - 120);
      burst = $urandom_range(0, 5);
      repeat (burst) begin
        s = SLOT_W'($urandom_range(0, SLOTS - 1));
        if ($urandom_range(0, 5) == 0) begin
          t   = last_t;
          sec = last_sec;
        end else if ($urandom_range(0, 7) == 0) begin
          t   = $urandom_range(0, 1) ? '1 : '0;
          sec = $urandom_range(0, 1) ? '1 : '0;
        end else begin
          t   = TRACK_W'($urandom());
          sec = SECTOR_W'($urandom());
        end
        last_t   = t;
        last_sec = sec;
        enqueue(s, t, sec, 1'($urandom()));
      end
      repeat ($urandom_range(1, burst + 1)) select_next();
    end
    gaps_on = 1'b0;
    in_valid <= 1'b0;

    while (awaited != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/edrs_pkg.sv
rtl/edrs_dist_cmp.sv
rtl/elevator_disk_request_selector_top.sv
sim/request_pick_checker.sv
sim/testbench.sv
